// File: rtl/disc_stamp_alpha_composite_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the disc stamp compositor
// Shared concurrent assertion forms, clocked on clk and quiet during rst.
// ----------------------------------------------------------------------------
`ifndef DISC_STAMP_ALPHA_COMPOSITE_MACROS_SVH
`define DISC_STAMP_ALPHA_COMPOSITE_MACROS_SVH

// same-cycle implication
`define DSAC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DSAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/dsac_pkg.sv
// ----------------------------------------------------------------------------
// dsac_pkg
// Types, codes and constants shared by the disc stamp compositor.
// ----------------------------------------------------------------------------
package dsac_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int MAX_RADIUS     = 20;

  // command codes
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_STAMP = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // register indexes
  localparam logic [2:0] REG_RED    = 3'd0;
  localparam logic [2:0] REG_GREEN  = 3'd1;
  localparam logic [2:0] REG_BLUE   = 3'd2;
  localparam logic [2:0] REG_ALPHA  = 3'd3;
  localparam logic [2:0] REG_RADIUS = 3'd4;
  localparam logic [2:0] REG_WIDTH  = 3'd5;
  localparam logic [2:0] REG_HEIGHT = 3'd6;

  localparam int IN_W  = 56;
  localparam int OUT_W = 48;

  localparam int SQRT_STEPS  = 22;
  localparam int FALL_STEPS  = 23;
  localparam int BLEND_STEPS = 8;

  // outA above 0.001 in units of 1/(255*65536)
  localparam logic [23:0] KEEP_LIMIT = 24'd16711;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] alpha;
    logic [4:0]  radius;
    logic [10:0] width;
    logic [10:0] height;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_WRITE_LOAD,
    OP_READ_ISSUE,
    OP_READ_LATCH,
    OP_STAMP_INIT,
    OP_STEP,
    OP_PIX_START,
    OP_SQRT_STEP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_MUL1,
    OP_MUL2,
    OP_MUL3,
    OP_BDIV_STEP,
    OP_WRITE_BLEND
  } op_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       rad_zero;
    logic       hit;
    logic       last;
  } dp_stat_t;

endpackage

// File: rtl/dsac_regs.sv
// ----------------------------------------------------------------------------
// dsac_regs
// APB configuration registers: stamp colour, opacity, radius, frame size.
// ----------------------------------------------------------------------------
module dsac_regs
  import dsac_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.red    <= 8'd255;
      cfg.green  <= 8'd255;
      cfg.blue   <= 8'd255;
      cfg.alpha  <= 16'd65535;
      cfg.radius <= 5'd2;
      cfg.width  <= 11'd1024;
      cfg.height <= 11'd1024;
    end else if (wr) begin
      unique case (idx)
        REG_RED:    cfg.red    <= pwdata[7:0];
        REG_GREEN:  cfg.green  <= pwdata[7:0];
        REG_BLUE:   cfg.blue   <= pwdata[7:0];
        REG_ALPHA:  cfg.alpha  <= pwdata[15:0];
        REG_RADIUS: cfg.radius <= pwdata[4:0];
        REG_WIDTH:  cfg.width  <= pwdata[10:0];
        REG_HEIGHT: cfg.height <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_RED:    prdata = {24'd0, cfg.red};
      REG_GREEN:  prdata = {24'd0, cfg.green};
      REG_BLUE:   prdata = {24'd0, cfg.blue};
      REG_ALPHA:  prdata = {16'd0, cfg.alpha};
      REG_RADIUS: prdata = {27'd0, cfg.radius};
      REG_WIDTH:  prdata = {21'd0, cfg.width};
      REG_HEIGHT: prdata = {21'd0, cfg.height};
      default:    prdata = 32'd0;
    endcase
  end

endmodule

// File: rtl/dsac_ctrl.sv
// ----------------------------------------------------------------------------
// dsac_ctrl
// Sequencer: decodes each item and steps the datapath through the disc.
// ----------------------------------------------------------------------------
`include "disc_stamp_alpha_composite_macros.svh"

module dsac_ctrl
  import dsac_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  output logic     m_tvalid,
  input  logic     m_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_READ_WAIT,
    ST_PIX,
    ST_SQRT,
    ST_DINIT,
    ST_DIV,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_BDIV,
    ST_WRITE,
    ST_RESULT
  } state_t;

  state_t     state;
  logic [4:0] cnt;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_RESULT);

  always_comb begin
    cmd.op = OP_NONE;
    unique case (state)
      ST_IDLE:      if (s_tvalid) cmd.op = OP_CAPTURE;
      ST_DISPATCH: begin
        priority if (stat.kind == CMD_LOAD) cmd.op = OP_WRITE_LOAD;
        else if (stat.kind == CMD_READ) cmd.op = OP_READ_ISSUE;
        else if (stat.kind == CMD_STAMP && !stat.rad_zero) cmd.op = OP_STAMP_INIT;
        else cmd.op = OP_NONE;
      end
      ST_READ_WAIT: cmd.op = OP_READ_LATCH;
      ST_PIX: begin
        priority if (stat.hit) cmd.op = OP_PIX_START;
        else if (!stat.last) cmd.op = OP_STEP;
        else cmd.op = OP_NONE;
      end
      ST_SQRT:      cmd.op = OP_SQRT_STEP;
      ST_DINIT:     cmd.op = OP_DIV_INIT;
      ST_DIV:       cmd.op = OP_DIV_STEP;
      ST_MUL1:      cmd.op = OP_MUL1;
      ST_MUL2:      cmd.op = OP_MUL2;
      ST_MUL3:      cmd.op = OP_MUL3;
      ST_BDIV:      cmd.op = OP_BDIV_STEP;
      ST_WRITE:     cmd.op = OP_WRITE_BLEND;
      ST_RESULT:    cmd.op = OP_NONE;
      default:      cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: if (s_tvalid) state <= ST_DISPATCH;
        ST_DISPATCH: begin
          priority if (stat.kind == CMD_READ) state <= ST_READ_WAIT;
          else if (stat.kind == CMD_STAMP && !stat.rad_zero) state <= ST_PIX;
          else state <= ST_RESULT;
        end
        ST_READ_WAIT: state <= ST_RESULT;
        ST_PIX: begin
          cnt <= '0;
          priority if (stat.hit) state <= ST_SQRT;
          else if (stat.last) state <= ST_RESULT;
          else state <= ST_PIX;
        end
        ST_SQRT: begin
          if (cnt == 5'(SQRT_STEPS - 1)) begin
            cnt   <= '0;
            state <= ST_DINIT;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        ST_DINIT: state <= ST_DIV;
        ST_DIV: begin
          if (cnt == 5'(FALL_STEPS - 1)) begin
            cnt   <= '0;
            state <= ST_MUL1;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        ST_MUL1: state <= ST_MUL2;
        ST_MUL2: state <= ST_MUL3;
        ST_MUL3: state <= ST_BDIV;
        ST_BDIV: begin
          if (cnt == 5'(BLEND_STEPS - 1)) begin
            cnt   <= '0;
            state <= ST_WRITE;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        ST_WRITE:  state <= stat.last ? ST_RESULT : ST_PIX;
        ST_RESULT: if (m_tready) state <= ST_IDLE;
        default:   state <= ST_IDLE;
      endcase
    end
  end

  `DSAC_ASSERT_NOW(a_no_overlap, s_tready, !m_tvalid, "input taken while result pending")
  `DSAC_ASSERT_NEXT(a_accept_decode, s_tvalid && s_tready, state == ST_DISPATCH, "no decode")
  `DSAC_ASSERT_NOW(a_div_bound, state == ST_DIV, cnt < 5'(FALL_STEPS), "divider overrun")
  `DSAC_ASSERT_NEXT(a_write_follows, state == ST_BDIV && cnt == 5'(BLEND_STEPS - 1),
                    state == ST_WRITE, "blend write skipped")

endmodule

// File: rtl/dsac_dp.sv
// ----------------------------------------------------------------------------
// dsac_dp
// Datapath: frame store, disc walk, distance root, falloff and blend units.
// ----------------------------------------------------------------------------
module dsac_dp
  import dsac_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)(
  input  logic             clk,
  input  cfg_t             cfg,
  input  logic [IN_W-1:0]  s_tdata,
  input  logic [1:0]       s_tuser,
  input  dp_cmd_t          cmd,
  output dp_stat_t         stat,
  output logic [OUT_W-1:0] m_tdata
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  logic [31:0] mem [DEPTH];
  logic [31:0] mem_q;

  logic [1:0]         kind;
  logic signed [11:0] cx, cy;
  logic [31:0]        ld_pix;
  logic signed [6:0]  dx, dy;
  logic [10:0]        count;
  logic [31:0]        rd_pix;
  logic               rd_ok;
  logic [AW-1:0]      addr_r;

  logic [42:0] sv, sres, sbit;
  logic [5:0]  rem;
  logic [22:0] dq;
  logic [15:0] f_r;
  logic [23:0] fia_r, num_r;
  logic [15:0] ca_r [3];
  logic [31:0] n_r [3];
  logic [30:0] dsh;
  logic [7:0]  q_r [3];

  // effective sizes
  logic [4:0]  rad;
  logic [6:0]  rad7;
  logic [12:0] effw, effh;
  logic signed [12:0] px, py;
  logic        in_fr;
  logic [AW-1:0] addr;
  logic [5:0]  adx, ady;
  logic [11:0] d2;
  logic [11:0] rad2;
  logic [5:0]  dvs;
  logic [7:0]  a_cur;
  logic [7:0]  s_col [3];
  logic [7:0]  c_cur [3];
  logic [43:0] s_try;
  logic [6:0]  d_try;
  logic [23:0] num_c;
  logic [16:0] fall;
  logic [32:0] fprod;
  logic        keep;
  logic [31:0] blend_pix;
  logic        we;
  logic [AW-1:0] waddr;
  logic [31:0] wdata;

  assign rad  = (cfg.radius > 5'(MAX_RADIUS)) ? 5'(MAX_RADIUS) : cfg.radius;
  assign rad7 = {2'b00, rad};
  assign effw = ({2'b00, cfg.width} > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : {2'b00, cfg.width};
  assign effh = ({2'b00, cfg.height} > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT)
                                                         : {2'b00, cfg.height};

  assign px = $signed({cx[11], cx}) + $signed({{6{dx[6]}}, dx});
  assign py = $signed({cy[11], cy}) + $signed({{6{dy[6]}}, dy});
  assign in_fr = !px[12] && !py[12] && ({1'b0, px[11:0]} < effw) &&
                 ({1'b0, py[11:0]} < effh);
  assign addr = AW'(AW'(py[11:0]) * AW'(MAX_WIDTH)) + AW'(px[11:0]);

  assign adx  = dx[6] ? 6'(-dx) : dx[5:0];
  assign ady  = dy[6] ? 6'(-dy) : dy[5:0];
  assign d2   = 12'(adx * adx) + 12'(ady * ady);
  assign rad2 = 12'(rad * rad);
  assign dvs  = {rad, 1'b1};

  assign stat.kind     = kind;
  assign stat.rad_zero = (rad == 5'd0);
  assign stat.hit      = in_fr && (d2 <= rad2);
  assign stat.last     = (dx == rad7) && (dy == rad7);

  assign a_cur    = mem_q[31:24];
  assign c_cur[0] = mem_q[7:0];
  assign c_cur[1] = mem_q[15:8];
  assign c_cur[2] = mem_q[23:16];
  assign s_col[0] = cfg.red;
  assign s_col[1] = cfg.green;
  assign s_col[2] = cfg.blue;

  assign s_try = {1'b0, sres} + {1'b0, sbit};
  assign d_try = {rem, dq[22]};
  assign num_c = {a_cur, 16'd0} + fia_r;
  assign fall  = 17'd65536 - {1'b0, dq[15:0]};
  assign fprod = 33'(cfg.alpha * fall);

  assign keep      = (num_r <= KEEP_LIMIT);
  assign blend_pix = keep ? {num_r[23:16], mem_q[23:0]}
                          : {num_r[23:16], q_r[2], q_r[1], q_r[0]};

  assign we    = ((cmd.op == OP_WRITE_LOAD) && in_fr) || (cmd.op == OP_WRITE_BLEND);
  assign waddr = (cmd.op == OP_WRITE_BLEND) ? addr_r : addr;
  assign wdata = (cmd.op == OP_WRITE_BLEND) ? blend_pix : ld_pix;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (cmd.op == OP_READ_ISSUE || cmd.op == OP_PIX_START) mem_q <= mem[addr];
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_CAPTURE: begin
        kind   <= s_tuser;
        cx     <= $signed(s_tdata[11:0]);
        cy     <= $signed(s_tdata[23:12]);
        ld_pix <= s_tdata[55:24];
        dx     <= '0;
        dy     <= '0;
        count  <= '0;
        rd_pix <= '0;
      end
      OP_READ_ISSUE: rd_ok <= in_fr;
      OP_READ_LATCH: if (rd_ok) rd_pix <= mem_q;
      OP_STAMP_INIT: begin
        dx <= $signed(7'(~rad7 + 7'd1));
        dy <= $signed(7'(~rad7 + 7'd1));
      end
      OP_STEP, OP_WRITE_BLEND: begin
        if (dx == rad7) begin
          dx <= $signed(7'(~rad7 + 7'd1));
          dy <= dy + 7'sd1;
        end else begin
          dx <= dx + 7'sd1;
        end
      end
      OP_PIX_START: begin
        addr_r <= addr;
        count  <= count + 11'd1;
        sv     <= {d2[10:0], 32'd0};
        sres   <= '0;
        sbit   <= {1'b1, 42'd0};
      end
      OP_SQRT_STEP: begin
        if ({1'b0, sv} >= s_try) begin
          sv   <= sv - s_try[42:0];
          sres <= (sres >> 1) + sbit;
        end else begin
          sres <= sres >> 1;
        end
        sbit <= sbit >> 2;
      end
      OP_DIV_INIT: begin
        dq  <= {sres[21:0], 1'b0};
        rem <= '0;
      end
      OP_DIV_STEP: begin
        if (d_try >= {1'b0, dvs}) begin
          rem <= 6'(d_try - {1'b0, dvs});
          dq  <= {dq[21:0], 1'b1};
        end else begin
          rem <= d_try[5:0];
          dq  <= {dq[21:0], 1'b0};
        end
      end
      OP_MUL1: f_r <= fprod[31:16];
      OP_MUL2: begin
        fia_r <= 24'(f_r * (8'd255 - a_cur));
        for (int i = 0; i < 3; i++) ca_r[i] <= 16'(c_cur[i] * a_cur);
      end
      OP_MUL3: begin
        num_r <= num_c;
        dsh   <= {num_c, 7'd0};
        for (int i = 0; i < 3; i++) begin
          n_r[i] <= {ca_r[i], 16'd0} + 32'(s_col[i] * fia_r);
          q_r[i] <= '0;
        end
      end
      OP_BDIV_STEP: begin
        // restoring division; the quotient never exceeds 255
        for (int i = 0; i < 3; i++) begin
          if (n_r[i] >= {1'b0, dsh}) begin
            n_r[i] <= n_r[i] - {1'b0, dsh};
            q_r[i] <= {q_r[i][6:0], 1'b1};
          end else begin
            q_r[i] <= {q_r[i][6:0], 1'b0};
          end
        end
        dsh <= dsh >> 1;
      end
      default: ;
    endcase
  end

  assign m_tdata = {5'd0, count, rd_pix};

endmodule

// File: rtl/disc_stamp_alpha_composite.sv
// ----------------------------------------------------------------------------
// disc_stamp_alpha_composite
// RGBA8 frame store with a soft-edged disc stamp composited destination-over.
// ----------------------------------------------------------------------------
// One item at a time, each giving one result. A stamp walks all (2r+1)^2
// offsets and passes over those outside the disc or the frame; each covered
// pixel goes through the distance root, the falloff divider, 3 multiply
// stages, the colour divider and one store write. Results wait in an output
// register until taken.
module disc_stamp_alpha_composite
  import dsac_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // pos_x[11:0], pos_y[23:12], load_red, load_green, load_blue, load_alpha
  input  logic [IN_W-1:0]  s_tdata,
  // command
  input  logic [1:0]       s_tuser,
  output logic             m_tvalid,
  input  logic             m_tready,
  // read_red, read_green, read_blue, read_alpha, pixels_blended[42:32]
  output logic [OUT_W-1:0] m_tdata,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  dsac_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  dsac_ctrl u_ctrl (
    .clk, .rst, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .stat, .cmd
  );

  dsac_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk, .cfg, .s_tdata, .s_tuser, .cmd, .stat, .m_tdata
  );

endmodule
